// ===== hw/rtl/ctl_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ctl_pkg - shared types and constants of the closed tour length unit
// Field widths, item kinds, read selects, the controller state type and the
// command and status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package ctl_pkg;

  // Fixed field widths of the stream words.
  localparam int IDX_W   = 12;
  localparam int COORD_W = 24;
  localparam int LEN_W   = 38;
  localparam int IN_DATA_W  = 64;
  localparam int OUT_DATA_W = 40;

  // Item kinds carried on tuser.
  localparam logic KIND_LOAD = 1'b0;
  localparam logic KIND_TOUR = 1'b1;

  // Which stored city index drives the coordinate table read.
  typedef enum logic [1:0] {
    RD_PREV  = 2'd0,
    RD_CUR   = 2'd1,
    RD_FIRST = 2'd2
  } rd_sel_t;

  // Controller states, one-hot.
  typedef enum logic [9:0] {
    S_IDLE = 10'b00_0000_0001,
    S_RD_A = 10'b00_0000_0010,
    S_RD_B = 10'b00_0000_0100,
    S_DIFF = 10'b00_0000_1000,
    S_SQX  = 10'b00_0001_0000,
    S_SQY  = 10'b00_0010_0000,
    S_ADD  = 10'b00_0100_0000,
    S_ROOT = 10'b00_1000_0000,
    S_ACC  = 10'b01_0000_0000,
    S_EMIT = 10'b10_0000_0000
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic    wr_load;     // write the accepted load word into the table
    logic    latch_tour;  // capture index and last mark of a tour word
    logic    start_tour;  // open a new tour at the accepted index
    rd_sel_t rd_sel;      // table read address select
    logic    cap_a;       // capture the first endpoint coordinates
    logic    cap_b;       // form absolute differences with the second endpoint
    logic    sq_x;        // square dx
    logic    sq_y;        // square dy
    logic    add_s;       // add the squares and start the root
    logic    root_step;   // one digit of the square root
    logic    acc;         // round the root and add it to the total
    logic    set_prev;    // previous city takes the current city
    logic    emit;        // load the output register and close the tour
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic tour_open;
    logic item_last;
    logic root_done;
    logic out_full;
  } sts_t;

endpackage

// ===== hw/rtl/ctl_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ctl_ctrl - sequencer of the closed tour length unit
// Accepts words while idle and steps the datapath through the edge
// computation: two table reads, squares, sum, serial root, accumulate.
// ----------------------------------------------------------------------------
module ctl_ctrl
  import ctl_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic in_tvalid,
  input  logic in_kind,
  input  logic in_last,
  output logic in_tready,
  input  sts_t sts,
  output cmd_t cmd
);

  state_t state_r, state_nxt;
  logic   closing_r, closing_nxt;
  logic   accept;

  assign in_tready = (state_r == S_IDLE);
  assign accept    = in_tready && in_tvalid;

  // Next state and command decode.
  always_comb begin
    state_nxt   = state_r;
    closing_nxt = closing_r;
    cmd         = '0;
    cmd.rd_sel  = RD_PREV;
    unique case (state_r)
      S_IDLE: begin
        if (accept && (in_kind == KIND_LOAD)) begin
          cmd.wr_load = 1'b1;
        end else if (accept) begin
          cmd.latch_tour = 1'b1;
          if (!sts.tour_open) begin
            // A new tour adds no edge; a one-city tour closes at once.
            cmd.start_tour = 1'b1;
            if (in_last) begin
              state_nxt = S_EMIT;
            end
          end else begin
            closing_nxt = 1'b0;
            state_nxt   = S_RD_A;
          end
        end
      end
      S_RD_A: begin
        cmd.rd_sel = RD_PREV;
        state_nxt  = S_RD_B;
      end
      S_RD_B: begin
        cmd.rd_sel = closing_r ? RD_FIRST : RD_CUR;
        cmd.cap_a  = 1'b1;
        state_nxt  = S_DIFF;
      end
      S_DIFF: begin
        cmd.cap_b = 1'b1;
        state_nxt = S_SQX;
      end
      S_SQX: begin
        cmd.sq_x  = 1'b1;
        state_nxt = S_SQY;
      end
      S_SQY: begin
        cmd.sq_y  = 1'b1;
        state_nxt = S_ADD;
      end
      S_ADD: begin
        cmd.add_s = 1'b1;
        state_nxt = S_ROOT;
      end
      S_ROOT: begin
        cmd.root_step = 1'b1;
        if (sts.root_done) begin
          state_nxt = S_ACC;
        end
      end
      S_ACC: begin
        cmd.acc = 1'b1;
        if (closing_r) begin
          state_nxt = S_EMIT;
        end else begin
          cmd.set_prev = 1'b1;
          if (sts.item_last) begin
            closing_nxt = 1'b1;
            state_nxt   = S_RD_A;
          end else begin
            state_nxt = S_IDLE;
          end
        end
      end
      S_EMIT: begin
        if (!sts.out_full) begin
          cmd.emit  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // State registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      closing_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      closing_r <= closing_nxt;
    end
  end

endmodule

// ===== hw/rtl/ctl_dp.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ctl_dp - datapath of the closed tour length unit
// Coordinate table, tour indices, shared squarer, digit-serial square root,
// saturating total and the output register.
// ----------------------------------------------------------------------------
module ctl_dp
  import ctl_pkg::*;
#(
  parameter int MAX_CITIES = 4096,
  parameter int COORD_BITS = 24
) (
  input  logic               clk,
  input  logic               rst_n,
  input  cmd_t               cmd,
  output sts_t               sts,
  input  logic [IDX_W-1:0]   in_city_index,
  input  logic [COORD_W-1:0] in_coord_x,
  input  logic [COORD_W-1:0] in_coord_y,
  input  logic               in_last,
  input  logic               out_tready,
  output logic               out_valid,
  output logic [LEN_W-1:0]   out_length
);

  localparam int CB = COORD_BITS;
  localparam int AW = $clog2(MAX_CITIES);
  localparam int XW = (AW > IDX_W) ? AW : IDX_W;
  localparam int EW = (CB > COORD_W) ? CB : COORD_W;
  localparam int RW = CB + 1;
  localparam int SW = 2 * RW;
  localparam int CW = $clog2(RW);

  // Table address from a city index.
  function automatic logic [AW-1:0] addr_of(input logic [IDX_W-1:0] idx);
    logic [XW-1:0] wide;
    wide = XW'(idx);
    return wide[AW-1:0];
  endfunction

  // True when the index lies inside the table.
  function automatic logic in_range(input logic [IDX_W-1:0] idx);
    return (32'(idx) < 32'(MAX_CITIES));
  endfunction

  // Absolute difference of two signed coordinates.
  function automatic logic [CB-1:0] abs_diff(input logic [CB-1:0] a,
                                             input logic [CB-1:0] b);
    logic signed [CB:0] d;
    d = $signed({a[CB-1], a}) - $signed({b[CB-1], b});
    return d[CB] ? CB'(-d) : d[CB-1:0];
  endfunction

  logic [CB-1:0] mem_x [MAX_CITIES];
  logic [CB-1:0] mem_y [MAX_CITIES];

  logic [IDX_W-1:0]  first_r, prev_r, cur_r, rd_idx;
  logic              open_r, last_r, rd_ok_r;
  logic [CB-1:0]     rd_x_r, rd_y_r, bx, by, ax_r, ay_r, dx_r, dy_r, mul_in;
  logic [2*CB-1:0]   prod, s_r, t_r;
  logic [SW-1:0]     rad_r;
  logic [RW+1:0]     rem_r;
  logic [RW-1:0]     root_r;
  logic [CW-1:0]     cnt_r;
  logic [RW+2:0]     shifted, trial;
  logic [RW+1:0]     edge_len;
  logic [LEN_W:0]    sum_tmp;
  logic [LEN_W-1:0]  sum_r, out_len_r;
  logic              out_valid_r;
  logic [EW-1:0]     ext_x, ext_y;
  logic [CB-1:0]     cx, cy;

  // Coordinates are the low COORD_BITS bits of the field.
  assign ext_x = EW'(in_coord_x);
  assign ext_y = EW'(in_coord_y);
  assign cx    = ext_x[CB-1:0];
  assign cy    = ext_y[CB-1:0];

  // Read address select.
  always_comb begin
    case (cmd.rd_sel)
      RD_PREV:  rd_idx = prev_r;
      RD_CUR:   rd_idx = cur_r;
      RD_FIRST: rd_idx = first_r;
      default:  rd_idx = prev_r;
    endcase
  end

  // Coordinate table: one write port for loads, one registered read port.
  always_ff @(posedge clk) begin
    if (cmd.wr_load && in_range(in_city_index)) begin
      mem_x[addr_of(in_city_index)] <= cx;
      mem_y[addr_of(in_city_index)] <= cy;
    end
    rd_x_r  <= mem_x[addr_of(rd_idx)];
    rd_y_r  <= mem_y[addr_of(rd_idx)];
    rd_ok_r <= in_range(rd_idx);
  end

  // A city outside the table reads as the origin.
  assign bx = rd_ok_r ? rd_x_r : '0;
  assign by = rd_ok_r ? rd_y_r : '0;

  // Shared squarer.
  assign mul_in = cmd.sq_y ? dy_r : dx_r;
  assign prod   = mul_in * mul_in;

  // One root digit: bring down two radicand bits and try root*4+1.
  assign shifted = {rem_r[RW:0], rad_r[SW-1 -: 2]};
  assign trial   = (RW+3)'({root_r, 2'b01});

  // Round to nearest: one more when the remainder exceeds the root.
  assign edge_len = (RW+2)'(root_r) + ((rem_r > (RW+2)'(root_r)) ? (RW+2)'(1) : '0);
  assign sum_tmp  = (LEN_W+1)'(sum_r) + (LEN_W+1)'(edge_len);

  // Edge arithmetic registers.
  always_ff @(posedge clk) begin
    if (cmd.cap_a) begin
      ax_r <= bx;
      ay_r <= by;
    end
    if (cmd.cap_b) begin
      dx_r <= abs_diff(ax_r, bx);
      dy_r <= abs_diff(ay_r, by);
    end
    if (cmd.sq_x) begin
      s_r <= prod;
    end
    if (cmd.sq_y) begin
      t_r <= prod;
    end
    if (cmd.add_s) begin
      rad_r  <= SW'(s_r) + SW'(t_r);
      rem_r  <= '0;
      root_r <= '0;
      cnt_r  <= '0;
    end else if (cmd.root_step) begin
      if (shifted >= trial) begin
        rem_r  <= (RW+2)'(shifted - trial);
        root_r <= {root_r[RW-2:0], 1'b1};
      end else begin
        rem_r  <= (RW+2)'(shifted);
        root_r <= {root_r[RW-2:0], 1'b0};
      end
      rad_r <= rad_r << 2;
      cnt_r <= cnt_r + 1'b1;
    end
  end

  // Tour state, total and output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      first_r     <= '0;
      prev_r      <= '0;
      open_r      <= 1'b0;
      sum_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.start_tour) begin
        first_r <= in_city_index;
        prev_r  <= in_city_index;
        sum_r   <= '0;
        open_r  <= 1'b1;
      end
      if (cmd.acc) begin
        sum_r <= sum_tmp[LEN_W] ? '1 : sum_tmp[LEN_W-1:0];
      end
      if (cmd.set_prev) begin
        prev_r <= cur_r;
      end
      if (out_valid_r && out_tready) begin
        out_valid_r <= 1'b0;
      end
      if (cmd.emit) begin
        out_valid_r <= 1'b1;
        open_r      <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch_tour) begin
      cur_r  <= in_city_index;
      last_r <= in_last;
    end
    if (cmd.emit) begin
      out_len_r <= sum_r;
    end
  end

  assign sts.tour_open = open_r;
  assign sts.item_last = last_r;
  assign sts.root_done = (cnt_r == CW'(RW - 1));
  assign sts.out_full  = out_valid_r;

  assign out_valid  = out_valid_r;
  assign out_length = out_len_r;

endmodule

// ===== hw/rtl/closed_tour_length_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// closed_tour_length_unit - length of a closed tour over a city table
// Load words fill a coordinate table; tour words name cities in order and
// the last one returns the sum of rounded Euclidean edge lengths.
// ----------------------------------------------------------------------------
//
//  Channel  Ports           Word contents
//  -------  --------------  ---------------------------------------------------
//  input    in_t*           tuser kind, tlast last city, tdata index/x/y
//  output   out_t*          tdata tour length
//
//  A load word is written into the table and the unit stays ready for the
//  next word. A tour word that adds an edge passes through two table reads,
//  difference, two squares on the shared multiplier, sum, COORD_BITS + 1 root
//  digits and the accumulate. A word marked last adds the closing edge as
//  well, then loads the output register. rst_n is synchronous; the table is
//  not cleared. A stalled output holds only tour words that must emit.
//
module closed_tour_length_unit
  import ctl_pkg::*;
#(
  parameter int MAX_CITIES = 4096,
  parameter int COORD_BITS = 24
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // [11:0] city_index, [35:12] coord_x, [59:36] coord_y, [63:60] zero
  input  logic [IN_DATA_W-1:0]  in_tdata,
  // [0] kind
  input  logic                  in_tuser,
  input  logic                  in_tlast,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // [37:0] tour_length, [39:38] zero
  output logic [OUT_DATA_W-1:0] out_tdata
);

  cmd_t             cmd;
  sts_t             sts;
  logic [LEN_W-1:0] out_length;

  // Sequencer.
  ctl_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_kind   (in_tuser),
    .in_last   (in_tlast),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // Datapath.
  ctl_dp #(
    .MAX_CITIES (MAX_CITIES),
    .COORD_BITS (COORD_BITS)
  ) u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .sts           (sts),
    .in_city_index (in_tdata[IDX_W-1:0]),
    .in_coord_x    (in_tdata[IDX_W+COORD_W-1:IDX_W]),
    .in_coord_y    (in_tdata[IDX_W+2*COORD_W-1:IDX_W+COORD_W]),
    .in_last       (in_tlast),
    .out_tready    (out_tready),
    .out_valid     (out_tvalid),
    .out_length    (out_length)
  );

  assign out_tdata = OUT_DATA_W'(out_length);

`ifndef NO_ASSERTIONS
  // The output register is loaded only when empty.
  a_emit_empty: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |-> !out_tvalid)
    else $error("result loaded over a waiting result");

  // A loaded result is offered in the following cycle.
  a_emit_shows: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |=> out_tvalid)
    else $error("loaded result not offered");

  // Datapath phases never overlap.
  a_phase_excl: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.cap_a, cmd.cap_b, cmd.sq_x, cmd.sq_y, cmd.add_s,
              cmd.root_step, cmd.acc, cmd.emit}))
    else $error("overlapping datapath commands");

  // No word is taken while an edge is in progress.
  a_busy_stall: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.root_step || cmd.acc) |-> !in_tready)
    else $error("input taken during edge computation");
`endif

endmodule
